// ===== src/nbvb_pkg.sv =====
// Package with shared types and constants for the nearest bone vertex binding block.
package nbvb_pkg;

    localparam logic [1:0] OP_LOAD_NODE = 2'd0;
    localparam logic [1:0] OP_LOAD_BONE = 2'd1;
    localparam logic [1:0] OP_BIND     = 2'd2;

    localparam int T_FRAC = 32;

    // Command from the sequencer to the shared divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

endpackage

// ===== src/nbvb_divider.sv =====
// Restoring fractional divider: quotient = floor(num * 2^32 / den) for num < den.
module nbvb_divider #(
    parameter int W = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nbvb_pkg::div_ctl_t           ctl,
    input  logic [W-1:0]                 num,
    input  logic [W-1:0]                 den,
    output logic                         done,
    output logic [nbvb_pkg::T_FRAC-1:0]  quot
);
    localparam int CW = $clog2(nbvb_pkg::T_FRAC + 1);

    logic [W:0]                    rem_reg, rem_next;
    logic [W-1:0]                  den_reg;
    logic [nbvb_pkg::T_FRAC-1:0]   q_reg, q_next;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic [W:0]                    shifted;

    always_comb
    begin
        shifted  = {rem_reg[W-1:0], 1'b0};
        rem_next = shifted;
        q_next   = {q_reg[nbvb_pkg::T_FRAC-2:0], 1'b0};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = shifted - {1'b0, den_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= !ctl.start && busy_reg && (cnt_reg == CW'(nbvb_pkg::T_FRAC - 1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(nbvb_pkg::T_FRAC - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quot = q_reg;
endmodule

// ===== src/nearest_bone_vertex_binding.sv =====
// Top level: node and bone stores, per-bone sequencer and result output register.
//
// Usage: items enter on the s_axis channel. tdata carries operation, slot,
// coord_x, coord_y, coord_z, start_index, end_index from the lowest bit up.
// A node or bone load is written to its store and produces nothing. A bind item
// walks the first bone_count bones, with 0 taken as 1 and the count capped at
// MAX_BONES and 64. A bone whose projection clamps to an end of the segment
// goes straight to the distance; when the vertex falls inside it, the shared
// 32-step divider and the offsets come first. The emit state then picks the
// result path; when the nearest point is a joint, two passes over the bones
// follow, the first counting the bones that share it and the second sending
// them. s_axis_tready is high only while the sequencer is idle. Results leave
// on m_axis: tdata holds bone_id and share_count, tlast marks the final bone
// for the vertex. A stalled receiver holds the sequencer at the result it
// offers. The bone_count register is written through
// cfg_valid/cfg_ready/cfg_data while idle. Reset clears the control state and
// sets bone_count to 1; stores are undefined until loaded.
module nearest_bone_vertex_binding #(
    parameter int MAX_BONES  = 64,
    parameter int MAX_NODES  = 64,
    parameter int COORD_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], slot[7:2], coord_x[31:8], coord_y[55:32], coord_z[79:56],
    // start_index[85:80], end_index[91:86], zero fill
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bone_id[5:0], share_count[12:6], zero fill
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 2;          // component differences
    localparam int PW  = 2 * DW + 3;      // sums of three products, with sign
    localparam int NB  = (MAX_BONES < 64) ? MAX_BONES : 64;
    localparam int BW  = 7;
    localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int BIW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_BRD, S_NRD_S, S_NRD_E, S_DIFF, S_MUL, S_DIV, S_DWAIT,
        S_OFF, S_DIST, S_CMP, S_MATCH_RD, S_MATCH_NS, S_MATCH_NE, S_MATCH_CHK,
        S_EMIT, S_OUT
    } state_t;

    state_t state_reg;

    // Stores.
    logic signed [CB-1:0] nx_mem [MAX_NODES];
    logic signed [CB-1:0] ny_mem [MAX_NODES];
    logic signed [CB-1:0] nz_mem [MAX_NODES];
    logic [11:0]          bone_mem [MAX_BONES];

    logic [1:0]  in_op;
    logic [5:0]  in_slot;
    logic [5:0]  in_si, in_ei;
    logic signed [CB-1:0] in_x, in_y, in_z;
    assign in_op   = s_axis_tdata[1:0];
    assign in_slot = s_axis_tdata[7:2];
    assign in_x    = s_axis_tdata[8 + CB - 1 : 8];
    assign in_y    = s_axis_tdata[32 + CB - 1 : 32];
    assign in_z    = s_axis_tdata[56 + CB - 1 : 56];
    assign in_si   = s_axis_tdata[85:80];
    assign in_ei   = s_axis_tdata[91:86];

    logic [6:0] bone_count_reg;
    logic [BW-1:0] n_bones;
    always_comb
    begin
        n_bones = bone_count_reg;
        if (n_bones == '0)
            n_bones = 7'd1;
        if (n_bones > BW'(NB))
            n_bones = BW'(NB);
    end

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Memory reads, registered.
    logic [5:0]  node_addr;
    logic [BW-1:0] bone_idx_reg;
    logic [11:0] bone_rd_reg;
    logic signed [CB-1:0] rx_reg, ry_reg, rz_reg;
    logic        nvalid_reg;

    always_ff @(posedge clk)
    begin
        if (accept && in_op == nbvb_pkg::OP_LOAD_NODE && {26'd0, in_slot} < MAX_NODES)
        begin
            nx_mem[NIW'(in_slot)] <= in_x;
            ny_mem[NIW'(in_slot)] <= in_y;
            nz_mem[NIW'(in_slot)] <= in_z;
        end
        if (accept && in_op == nbvb_pkg::OP_LOAD_BONE && {26'd0, in_slot} < MAX_BONES)
            bone_mem[BIW'(in_slot)] <= {in_si, in_ei};
        bone_rd_reg <= bone_mem[BIW'(bone_idx_reg[5:0])];
        rx_reg      <= nx_mem[NIW'(node_addr)];
        ry_reg      <= ny_mem[NIW'(node_addr)];
        rz_reg      <= nz_mem[NIW'(node_addr)];
        nvalid_reg  <= ({26'd0, node_addr} < MAX_NODES);
    end

    logic signed [CB-1:0] node_x, node_y, node_z;
    assign node_x = nvalid_reg ? rx_reg : '0;
    assign node_y = nvalid_reg ? ry_reg : '0;
    assign node_z = nvalid_reg ? rz_reg : '0;

    // Working registers.
    logic signed [CB-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [CB-1:0] sx_reg, sy_reg, sz_reg, ex_reg, ey_reg, ez_reg;
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic signed [PW-1:0] dot_reg, len_reg, dist_reg, best_d_reg;
    logic signed [CB+1:0] px_reg, py_reg, pz_reg, bpx_reg, bpy_reg, bpz_reg;
    logic [1:0]  k_reg;
    logic [2:0]  mstep_reg;
    logic [31:0] t_reg;
    logic [BW-1:0] best_reg, count_reg, seen_reg;
    logic [1:0]  pass_reg;
    logic        hit_reg;
    logic [5:0]  out_id_reg;
    logic        out_last_reg;

    // Shared multiplier: one signed product per cycle, operands selected by step.
    logic signed [DW:0]     mul_a, mul_b;
    logic signed [2*DW+1:0] mul_p;
    logic signed [CB+1:0]   p_sel;
    always_comb
    begin
        p_sel = px_reg;
        if (k_reg == 2'd1)
            p_sel = py_reg;
        else if (k_reg == 2'd2)
            p_sel = pz_reg;
        case (mstep_reg)
            3'd0:    begin mul_a = {ab_reg[k_reg][DW-1], ab_reg[k_reg]};
                           mul_b = {ac_reg[k_reg][DW-1], ac_reg[k_reg]}; end
            3'd1:    begin mul_a = {ab_reg[k_reg][DW-1], ab_reg[k_reg]};
                           mul_b = {ab_reg[k_reg][DW-1], ab_reg[k_reg]}; end
            default: begin
                mul_a = (DW+1)'(p_sel) - (DW+1)'(k_reg == 2'd0 ? vx_reg :
                                                   k_reg == 2'd1 ? vy_reg : vz_reg);
                mul_b = mul_a;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Offset: |ab| * t rounded, using the upper bits.
    logic [DW-1:0]  ab_mag;
    logic [DW+31:0] off_prod;
    logic [DW-1:0]  off_val;
    logic signed [CB+1:0] s_sel, p_new;
    always_comb
    begin
        ab_mag   = ab_reg[k_reg][DW-1] ? DW'(-ab_reg[k_reg]) : DW'(ab_reg[k_reg]);
        off_prod = ab_mag * t_reg + (DW+32)'(64'h8000_0000);
        off_val  = off_prod[DW+31:32];
        s_sel    = (CB+2)'(k_reg == 2'd0 ? sx_reg : k_reg == 2'd1 ? sy_reg : sz_reg);
        p_new    = ab_reg[k_reg][DW-1] ? s_sel - (CB+2)'(off_val) : s_sel + (CB+2)'(off_val);
    end

    nbvb_pkg::div_ctl_t div_ctl;
    logic        div_done;
    logic [31:0] div_q;
    assign div_ctl.start = (state_reg == S_DIV);

    nbvb_divider #(.W(PW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (div_ctl),
        .num  (dot_reg),
        .den  (len_reg),
        .done (div_done),
        .quot (div_q)
    );

    // The start node is addressed first, the end node in the following cycle.
    always_comb
    begin
        node_addr = bone_rd_reg[5:0];
        if (state_reg == S_NRD_S || state_reg == S_MATCH_NS)
            node_addr = bone_rd_reg[11:6];
    end

    logic ns_match, ne_match;
    assign ns_match = ((CB+2)'(node_x) == bpx_reg) && ((CB+2)'(node_y) == bpy_reg)
                   && ((CB+2)'(node_z) == bpz_reg);
    assign ne_match = ns_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bone_count_reg <= 7'd1;
            m_axis_tvalid  <= 1'b0;
            bone_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                bone_count_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_op == nbvb_pkg::OP_BIND)
                    begin
                        vx_reg <= in_x;
                        vy_reg <= in_y;
                        vz_reg <= in_z;
                        bone_idx_reg <= '0;
                        state_reg <= S_BRD;
                    end
                end
                S_BRD:    state_reg <= S_NRD_S;
                S_NRD_S:  state_reg <= S_NRD_E;   // start node address issued
                S_NRD_E:
                begin
                    sx_reg <= node_x; sy_reg <= node_y; sz_reg <= node_z;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    ex_reg <= node_x; ey_reg <= node_y; ez_reg <= node_z;
                    ab_reg[0] <= DW'(node_x) - DW'(sx_reg);
                    ab_reg[1] <= DW'(node_y) - DW'(sy_reg);
                    ab_reg[2] <= DW'(node_z) - DW'(sz_reg);
                    ac_reg[0] <= DW'(vx_reg) - DW'(sx_reg);
                    ac_reg[1] <= DW'(vy_reg) - DW'(sy_reg);
                    ac_reg[2] <= DW'(vz_reg) - DW'(sz_reg);
                    dot_reg <= '0; len_reg <= '0;
                    k_reg <= 2'd0; mstep_reg <= 3'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mstep_reg == 3'd0)
                    begin
                        dot_reg <= dot_reg + PW'(mul_p);
                        mstep_reg <= 3'd1;
                    end
                    else
                    begin
                        len_reg <= len_reg + PW'(mul_p);
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= 2'd0;
                            if (dot_reg <= 0)
                            begin
                                px_reg <= sx_reg; py_reg <= sy_reg; pz_reg <= sz_reg;
                                state_reg <= S_DIST;
                                dist_reg <= '0; mstep_reg <= 3'd2;
                            end
                            else if (dot_reg >= len_reg + PW'(mul_p))
                            begin
                                px_reg <= ex_reg; py_reg <= ey_reg; pz_reg <= ez_reg;
                                state_reg <= S_DIST;
                                dist_reg <= '0; mstep_reg <= 3'd2;
                            end
                            else
                            begin
                                mstep_reg <= 3'd0;
                                state_reg <= S_DIV;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            mstep_reg <= 3'd0;
                        end
                    end
                end
                S_DIV:    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        t_reg <= div_q;
                        k_reg <= 2'd0;
                        state_reg <= S_OFF;
                    end
                end
                S_OFF:
                begin
                    if (k_reg == 2'd0) px_reg <= p_new;
                    if (k_reg == 2'd1) py_reg <= p_new;
                    if (k_reg == 2'd2) pz_reg <= p_new;
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= 2'd0; dist_reg <= '0; mstep_reg <= 3'd2;
                        state_reg <= S_DIST;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_DIST:
                begin
                    dist_reg <= dist_reg + PW'(mul_p);
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= 2'd0;
                        state_reg <= S_CMP;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_CMP:
                begin
                    if (bone_idx_reg == '0 || dist_reg < best_d_reg)
                    begin
                        best_reg <= bone_idx_reg; best_d_reg <= dist_reg;
                        bpx_reg <= px_reg; bpy_reg <= py_reg; bpz_reg <= pz_reg;
                        hit_reg <= ((px_reg == (CB+2)'(sx_reg)) && (py_reg == (CB+2)'(sy_reg))
                                    && (pz_reg == (CB+2)'(sz_reg)))
                                || ((px_reg == (CB+2)'(ex_reg)) && (py_reg == (CB+2)'(ey_reg))
                                    && (pz_reg == (CB+2)'(ez_reg)));
                    end
                    if (bone_idx_reg + 1'b1 == n_bones)
                    begin
                        bone_idx_reg <= '0;
                        count_reg <= '0; seen_reg <= '0; pass_reg <= 2'd0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        bone_idx_reg <= bone_idx_reg + 1'b1;
                        state_reg <= S_BRD;
                    end
                end
                S_EMIT:
                begin
                    if (!hit_reg)
                    begin
                        out_id_reg <= best_reg[5:0]; count_reg <= 7'd1;
                        out_last_reg <= 1'b1; m_axis_tvalid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_MATCH_RD;
                end
                S_MATCH_RD: state_reg <= S_MATCH_NS;
                S_MATCH_NS: state_reg <= S_MATCH_NE;
                S_MATCH_NE:
                begin
                    hit_reg <= ns_match;
                    state_reg <= S_MATCH_CHK;
                end
                S_MATCH_CHK:
                begin
                    if (hit_reg || ne_match)
                    begin
                        if (pass_reg == 2'd0)
                            count_reg <= count_reg + 1'b1;
                        else
                        begin
                            out_id_reg <= bone_idx_reg[5:0];
                            out_last_reg <= (seen_reg + 1'b1 == count_reg);
                            seen_reg <= seen_reg + 1'b1;
                            m_axis_tvalid <= 1'b1;
                        end
                    end
                    hit_reg <= 1'b1;
                    if (pass_reg != 2'd0 && (hit_reg || ne_match))
                        state_reg <= S_OUT;
                    else if (bone_idx_reg + 1'b1 == n_bones)
                    begin
                        if (pass_reg == 2'd0)
                        begin
                            pass_reg <= 2'd1; bone_idx_reg <= '0;
                            state_reg <= S_MATCH_RD;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                    else
                    begin
                        bone_idx_reg <= bone_idx_reg + 1'b1;
                        state_reg <= S_MATCH_RD;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        if (out_last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            bone_idx_reg <= bone_idx_reg + 1'b1;
                            state_reg <= S_MATCH_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {3'd0, count_reg, out_id_reg};
    assign m_axis_tlast = out_last_reg;
endmodule

// ===== src/nbvb_checker.sv =====
// Port-level checker for the nearest bone vertex binding block, bound to the top level.
module nbvb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        cfg_ready
);
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result pending");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == s_axis_tready) else $error("config ready differs from input ready");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:6] != 7'd0) else $error("zero share count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result dropped while stalled");
endmodule

bind nearest_bone_vertex_binding nbvb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .cfg_ready(cfg_ready)
);
